FILE: hdl/cfsu_pkg.sv
package cfsu_pkg;

  localparam int unsigned MaxOrder = 8;
  localparam int unsigned FracBits = 12;
  localparam int unsigned DataW    = 16;
  localparam int unsigned AccW     = 40;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned OrderW   = 4;
  localparam int unsigned NumW     = AccW + 1;
  localparam int unsigned ProdW    = 2 * DataW;
  localparam int unsigned MemW     = 2 * DataW;
  localparam int unsigned NumLanes = 2;
  localparam int unsigned DivCntW  = $clog2(DataW + 1);

  localparam logic [OrderW-1:0] OrderReset = OrderW'(4);

  typedef logic [IdxW-1:0]          idx_t;
  typedef logic signed [DataW-1:0]  data_t;
  typedef logic signed [AccW-1:0]   acc_t;
  typedef logic signed [NumW-1:0]   num_t;
  typedef logic [OrderW-1:0]        order_t;

  typedef struct packed {
    idx_t  row;
    idx_t  col;
    data_t l_real;
    data_t l_imag;
    data_t z_real;
    data_t z_imag;
  } in_item_t;

  typedef struct packed {
    idx_t  out_row;
    data_t u_real;
    data_t u_imag;
    logic  div_error;
    logic  last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_ABS,
    S_PREP,
    S_CHK,
    S_DIV,
    S_DONE
  } state_e;

endpackage

FILE: hdl/cfsu_if.sv
interface cfsu_in_if;
  logic               valid;
  logic               ready;
  cfsu_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cfsu_out_if;
  logic                valid;
  logic                ready;
  cfsu_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cfsu_cfg_if;
  logic             valid;
  logic             ready;
  cfsu_pkg::order_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/complex_forward_substitution_unit.sv
// channel   dir  payload                                      transaction
// in_ch     in   row, col, l_real, l_imag, z_real, z_imag     valid & ready
// out_ch    out  out_row, u_real, u_imag, div_error, last     valid & ready
// cfg_ch    in   order                                        valid & ready
//
// one element at a time: ignored elements are dropped on acceptance, off-diagonal elements go
// through solution ram read, four products and accumulate, diagonal elements through the
// 16-step bit-serial divider that handles real and imaginary parts side by side; a diagonal
// <= 0 skips the divider. rst_ni clears control state, accumulators and order
// (back to 4); the solution ram is not cleared. a result waiting on out_ch stalls only
// the next diagonal element at its final cycle.
module complex_forward_substitution_unit (
  input logic         clk_i,
  input logic         rst_ni,
  cfsu_in_if.sink     in_ch,
  cfsu_out_if.source  out_ch,
  cfsu_cfg_if.sink    cfg_ch
);

  localparam cfsu_pkg::acc_t AccMax = {1'b0, {(cfsu_pkg::AccW-1){1'b1}}};
  localparam cfsu_pkg::acc_t AccMin = {1'b1, {(cfsu_pkg::AccW-1){1'b0}}};
  localparam cfsu_pkg::data_t DataMax = {1'b0, {(cfsu_pkg::DataW-1){1'b1}}};
  localparam cfsu_pkg::data_t DataMin = {1'b1, {(cfsu_pkg::DataW-1){1'b0}}};
  localparam int unsigned HiW = cfsu_pkg::NumW - cfsu_pkg::DataW;

  cfsu_pkg::state_e state_q, state_d;
  cfsu_pkg::order_t order_q;
  cfsu_pkg::acc_t   acc_q [cfsu_pkg::NumLanes];
  cfsu_pkg::acc_t   acc_d [cfsu_pkg::NumLanes];

  logic [cfsu_pkg::MemW-1:0] sol_mem [cfsu_pkg::MaxOrder];
  logic [cfsu_pkg::MemW-1:0] sol_rd_q;

  cfsu_pkg::idx_t   row_q;
  cfsu_pkg::data_t  l_re_q, l_im_q;
  logic             err_q;
  logic signed [cfsu_pkg::ProdW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;

  cfsu_pkg::num_t            num_q [cfsu_pkg::NumLanes];
  logic                      neg_q [cfsu_pkg::NumLanes];
  logic [cfsu_pkg::NumW-1:0] mag_q [cfsu_pkg::NumLanes];
  logic [cfsu_pkg::NumW-1:0] dvd_q [cfsu_pkg::NumLanes];
  logic                      ovf_q [cfsu_pkg::NumLanes];
  logic [cfsu_pkg::DataW-1:0] rem_q [cfsu_pkg::NumLanes];
  logic [cfsu_pkg::DataW-1:0] rem_d [cfsu_pkg::NumLanes];
  logic [cfsu_pkg::DataW-1:0] sh_q  [cfsu_pkg::NumLanes];
  logic [cfsu_pkg::DataW-1:0] sh_d  [cfsu_pkg::NumLanes];
  cfsu_pkg::data_t            res   [cfsu_pkg::NumLanes];
  logic [cfsu_pkg::DivCntW-1:0] cnt_q;

  logic                out_valid_q;
  cfsu_pkg::out_item_t out_q;

  logic in_fire, in_use, in_off, in_diag_err, done_fire, mem_re;
  logic [cfsu_pkg::DataW:0]   den_ext;
  logic [cfsu_pkg::NumW-1:0]  half_ext;
  logic signed [cfsu_pkg::DataW-1:0] u_re, u_im;
  logic signed [cfsu_pkg::NumW-1:0]  step_sum [cfsu_pkg::NumLanes];
  cfsu_pkg::num_t                    z_ext [cfsu_pkg::NumLanes];

  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

  assign in_fire     = in_ch.valid & in_ch.ready;
  assign in_use      = ({1'b0, in_ch.data.row} < order_q) && (in_ch.data.col <= in_ch.data.row);
  assign in_off      = in_ch.data.col < in_ch.data.row;
  assign in_diag_err = in_ch.data.l_real[cfsu_pkg::DataW-1] || (in_ch.data.l_real == '0);

  assign u_re = sol_rd_q[cfsu_pkg::DataW-1:0];
  assign u_im = sol_rd_q[cfsu_pkg::MemW-1:cfsu_pkg::DataW];

  assign den_ext  = {1'b0, l_re_q};
  assign half_ext = {{(HiW+1){1'b0}}, l_re_q[cfsu_pkg::DataW-1:1]};

  assign z_ext[0] = {{HiW{in_ch.data.z_real[cfsu_pkg::DataW-1]}}, in_ch.data.z_real};
  assign z_ext[1] = {{HiW{in_ch.data.z_imag[cfsu_pkg::DataW-1]}}, in_ch.data.z_imag};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cfsu_pkg::S_IDLE: begin
        if (in_fire && in_use) begin
          if (in_off) begin
            state_d = cfsu_pkg::S_MUL;
          end else if (in_diag_err) begin
            state_d = cfsu_pkg::S_DONE;
          end else begin
            state_d = cfsu_pkg::S_ABS;
          end
        end
      end
      cfsu_pkg::S_MUL:  state_d = cfsu_pkg::S_ACC;
      cfsu_pkg::S_ACC:  state_d = cfsu_pkg::S_IDLE;
      cfsu_pkg::S_ABS:  state_d = cfsu_pkg::S_PREP;
      cfsu_pkg::S_PREP: state_d = cfsu_pkg::S_CHK;
      cfsu_pkg::S_CHK:  state_d = cfsu_pkg::S_DIV;
      cfsu_pkg::S_DIV: begin
        if (cnt_q == '0) begin
          state_d = cfsu_pkg::S_DONE;
        end
      end
      cfsu_pkg::S_DONE: begin
        if (done_fire) begin
          state_d = cfsu_pkg::S_IDLE;
        end
      end
      default: state_d = cfsu_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    done_fire   = 1'b0;
    mem_re      = 1'b0;
    unique case (state_q)
      cfsu_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        mem_re      = in_ch.valid && in_use && in_off;
      end
      cfsu_pkg::S_DONE: done_fire = !out_valid_q || out_ch.ready;
      default: ;
    endcase
  end

  // accumulate, divider step and saturation per lane
  always_comb begin
    logic signed [cfsu_pkg::ProdW:0] prod_sum;
    logic [cfsu_pkg::DataW:0]        trial;
    logic [cfsu_pkg::DataW-1:0]      q;
    for (int l = 0; l < cfsu_pkg::NumLanes; l++) begin
      if (l == 0) begin
        prod_sum = {p_rr_q[cfsu_pkg::ProdW-1], p_rr_q} - {p_ii_q[cfsu_pkg::ProdW-1], p_ii_q};
      end else begin
        prod_sum = {p_ri_q[cfsu_pkg::ProdW-1], p_ri_q} + {p_ir_q[cfsu_pkg::ProdW-1], p_ir_q};
      end
      step_sum[l] = {acc_q[l][cfsu_pkg::AccW-1], acc_q[l]}
                  + {{(cfsu_pkg::NumW-cfsu_pkg::ProdW-1){prod_sum[cfsu_pkg::ProdW]}}, prod_sum};
      if (step_sum[l] > $signed({AccMax[cfsu_pkg::AccW-1], AccMax})) begin
        acc_d[l] = AccMax;
      end else if (step_sum[l] < $signed({AccMin[cfsu_pkg::AccW-1], AccMin})) begin
        acc_d[l] = AccMin;
      end else begin
        acc_d[l] = step_sum[l][cfsu_pkg::AccW-1:0];
      end

      trial = {rem_q[l], sh_q[l][cfsu_pkg::DataW-1]};
      if (trial >= den_ext) begin
        trial    = trial - den_ext;
        sh_d[l]  = {sh_q[l][cfsu_pkg::DataW-2:0], 1'b1};
      end else begin
        sh_d[l]  = {sh_q[l][cfsu_pkg::DataW-2:0], 1'b0};
      end
      rem_d[l] = trial[cfsu_pkg::DataW-1:0];

      q = sh_q[l];
      if (neg_q[l]) begin
        if (ovf_q[l] || (q[cfsu_pkg::DataW-1] && |q[cfsu_pkg::DataW-2:0])) begin
          res[l] = DataMin;
        end else begin
          res[l] = -$signed(q);
        end
      end else begin
        if (ovf_q[l] || q[cfsu_pkg::DataW-1]) begin
          res[l] = DataMax;
        end else begin
          res[l] = $signed(q);
        end
      end
    end
  end

  // solution ram
  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      sol_mem[row_q] <= err_q ? '0 : {res[1], res[0]};
    end
    if (mem_re) begin
      sol_rd_q <= sol_mem[in_ch.data.col];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfsu_pkg::S_IDLE;
      order_q     <= cfsu_pkg::OrderReset;
      out_valid_q <= 1'b0;
      for (int l = 0; l < cfsu_pkg::NumLanes; l++) begin
        acc_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_ch.valid) begin
        order_q <= cfg_ch.data;
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      for (int l = 0; l < cfsu_pkg::NumLanes; l++) begin
        if (done_fire) begin
          acc_q[l] <= '0;
        end else if (state_q == cfsu_pkg::S_ACC) begin
          acc_q[l] <= acc_d[l];
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      cfsu_pkg::S_IDLE: begin
        if (in_fire) begin
          row_q  <= in_ch.data.row;
          l_re_q <= in_ch.data.l_real;
          l_im_q <= in_ch.data.l_imag;
          err_q  <= in_diag_err;
          for (int l = 0; l < cfsu_pkg::NumLanes; l++) begin
            num_q[l] <= (z_ext[l] <<< cfsu_pkg::FracBits)
                      - {acc_q[l][cfsu_pkg::AccW-1], acc_q[l]};
          end
        end
      end
      cfsu_pkg::S_MUL: begin
        p_rr_q <= cfsu_pkg::ProdW'(l_re_q) * cfsu_pkg::ProdW'(u_re);
        p_ii_q <= cfsu_pkg::ProdW'(l_im_q) * cfsu_pkg::ProdW'(u_im);
        p_ri_q <= cfsu_pkg::ProdW'(l_re_q) * cfsu_pkg::ProdW'(u_im);
        p_ir_q <= cfsu_pkg::ProdW'(l_im_q) * cfsu_pkg::ProdW'(u_re);
      end
      cfsu_pkg::S_ABS: begin
        for (int l = 0; l < cfsu_pkg::NumLanes; l++) begin
          neg_q[l] <= num_q[l][cfsu_pkg::NumW-1];
          mag_q[l] <= num_q[l][cfsu_pkg::NumW-1] ? -num_q[l] : num_q[l];
        end
      end
      cfsu_pkg::S_PREP: begin
        for (int l = 0; l < cfsu_pkg::NumLanes; l++) begin
          dvd_q[l] <= mag_q[l] + half_ext;
        end
      end
      cfsu_pkg::S_CHK: begin
        cnt_q <= cfsu_pkg::DivCntW'(cfsu_pkg::DataW - 1);
        for (int l = 0; l < cfsu_pkg::NumLanes; l++) begin
          ovf_q[l] <= dvd_q[l][cfsu_pkg::NumW-1:cfsu_pkg::DataW]
                      >= {{(HiW-cfsu_pkg::DataW){1'b0}}, l_re_q};
          rem_q[l] <= dvd_q[l][cfsu_pkg::DataW +: cfsu_pkg::DataW];
          sh_q[l]  <= dvd_q[l][cfsu_pkg::DataW-1:0];
        end
      end
      cfsu_pkg::S_DIV: begin
        cnt_q <= cnt_q - cfsu_pkg::DivCntW'(1);
        for (int l = 0; l < cfsu_pkg::NumLanes; l++) begin
          rem_q[l] <= rem_d[l];
          sh_q[l]  <= sh_d[l];
        end
      end
      cfsu_pkg::S_DONE: begin
        if (done_fire) begin
          out_q.out_row   <= row_q;
          out_q.u_real    <= err_q ? '0 : res[0];
          out_q.u_imag    <= err_q ? '0 : res[1];
          out_q.div_error <= err_q;
          out_q.last      <= ({1'b0, row_q} + cfsu_pkg::OrderW'(1)) == order_q;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: verif/cfsu_solution_checker.sv
`timescale 1ns / 1ps
module cfsu_solution_checker
  import cfsu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cfsu_in_if   in_ch,
  cfsu_out_if  out_ch,
  cfsu_cfg_if  cfg_ch,
  output int   mismatches_o,
  output int   pending_o,
  output int   solved_o,
  output int   div_errors_o
);

  order_t    order_q;
  data_t     sol_re [MaxOrder];
  data_t     sol_im [MaxOrder];
  acc_t      acc_re;
  acc_t      acc_im;
  out_item_t solutions_due [$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    solved_o     = 0;
    div_errors_o = 0;
  end

  function automatic longint clamp_acc(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (AccW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic data_t sat_word(longint v);
    if (v > 32767) return data_t'(32767);
    if (v < -32768) return data_t'(-32768);
    return data_t'(v);
  endfunction

  // nearest, ties away from zero; den is positive
  function automatic longint div_nearest(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic void apply_element(in_item_t it);
    longint    lr;
    longint    li;
    longint    ur;
    longint    ui;
    longint    nr;
    longint    ni;
    out_item_t res;
    lr = longint'($signed(it.l_real));
    li = longint'($signed(it.l_imag));
    if (it.row >= order_q || it.col > it.row) return;
    if (it.col < it.row) begin
      ur = longint'($signed(sol_re[it.col]));
      ui = longint'($signed(sol_im[it.col]));
      acc_re = acc_t'(clamp_acc(longint'(acc_re) + (lr * ur - li * ui)));
      acc_im = acc_t'(clamp_acc(longint'(acc_im) + (lr * ui + li * ur)));
      return;
    end
    res.out_row   = it.row;
    res.div_error = (lr <= 0);
    res.last      = (int'(it.row) + 1 == int'(order_q));
    if (res.div_error) begin
      res.u_real = '0;
      res.u_imag = '0;
    end else begin
      nr = longint'($signed(it.z_real)) * (longint'(1) <<< FracBits) - longint'(acc_re);
      ni = longint'($signed(it.z_imag)) * (longint'(1) <<< FracBits) - longint'(acc_im);
      res.u_real = sat_word(div_nearest(nr, lr));
      res.u_imag = sat_word(div_nearest(ni, lr));
    end
    sol_re[it.row] = res.u_real;
    sol_im[it.row] = res.u_imag;
    acc_re = '0;
    acc_im = '0;
    solutions_due.push_back(res);
  endfunction

  function automatic void check_solution(out_item_t got);
    out_item_t want;
    if (solutions_due.size() == 0) begin
      mismatches_o++;
      if (mismatches_o <= 10)
        $display("unexpected result: row %0d u %0d,%0d err %0b last %0b", got.out_row,
                 $signed(got.u_real), $signed(got.u_imag), got.div_error, got.last);
      return;
    end
    want = solutions_due.pop_front();
    solved_o++;
    if (want.div_error) div_errors_o++;
    if (got.out_row !== want.out_row || got.u_real !== want.u_real ||
        got.u_imag !== want.u_imag || got.div_error !== want.div_error ||
        got.last !== want.last) begin
      mismatches_o++;
      if (mismatches_o <= 10)
        $display("result mismatch: expected row %0d u %0d,%0d err %0b last %0b, got row %0d u %0d,%0d err %0b last %0b",
                 want.out_row, $signed(want.u_real), $signed(want.u_imag), want.div_error,
                 want.last, got.out_row, $signed(got.u_real), $signed(got.u_imag),
                 got.div_error, got.last);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q = OrderReset;
      acc_re  = '0;
      acc_im  = '0;
      solutions_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_solution(out_ch.data);
      if (cfg_ch.valid && cfg_ch.ready) order_q = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) apply_element(in_ch.data);
    end
    pending_o = solutions_due.size();
  end

endmodule

FILE: verif/complex_forward_substitution_unit_test.sv
`timescale 1ns / 1ps
module complex_forward_substitution_unit_test;
  import cfsu_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 40;
  localparam int HoldAfter    = 250;
  localparam int HoldCycles   = 600;
  localparam int NumPhases    = 12;
  localparam int PhaseItems   = 58;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cfsu_in_if  in_ch ();
  cfsu_out_if out_ch ();
  cfsu_cfg_if cfg_ch ();

  int mismatches;
  int pending;
  int solved;
  int div_errors;

  order_t               order_now = OrderReset;
  logic  [MaxOrder-1:0] written   = '0;
  int unsigned          counted   = 0;
  bit                   quiet     = 1'b0;
  bit                   held      = 1'b0;
  int                   cycles    = 0;

  order_t phase_orders [NumPhases] = '{1, 8, 0, 15, 3, 8, 2, 5, 7, 6, 1, 8};

  always #5 clk_i = ~clk_i;

  complex_forward_substitution_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cfsu_solution_checker solution_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .solved_o     (solved),
    .div_errors_o (div_errors)
  );

  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic data_t any16();
    return data_t'($urandom);
  endfunction

  function automatic data_t off_value();
    case ($urandom_range(0, 2))
      0: return data_t'($urandom);
      1: return data_t'(int'($urandom_range(0, 16384)) - 8192);
      default: return data_t'(int'($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  function automatic data_t diag_value();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return data_t'(-int'($urandom_range(1, 32768)));
      2: return data_t'($urandom_range(1, 32));
      3: return data_t'($urandom_range(1, 32767));
      default: return data_t'($urandom_range(2048, 12288));
    endcase
  endfunction

  function automatic data_t z_value();
    if ($urandom_range(0, 1) == 0) return data_t'($urandom);
    return data_t'(int'($urandom_range(0, 8192)) - 4096);
  endfunction

  task automatic send_element(int unsigned r, int unsigned c, data_t lr, data_t li, data_t zr,
                              data_t zi);
    in_item_t it;
    it.row    = idx_t'(r);
    it.col    = idx_t'(c);
    it.l_real = lr;
    it.l_imag = li;
    it.z_real = zr;
    it.z_imag = zi;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (r < order_now && c <= r) begin
      counted++;
      if (c == r) written[r] = 1'b1;
    end
  endtask

  task automatic write_order(order_t v);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    order_now = v;
  endtask

  // full system row by row, now and then an off-diagonal transaction dropped or the system cut short
  task automatic solve_system(int unsigned n);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < r; c++)
        if ($urandom_range(0, 9) != 0)
          send_element(r, c, off_value(), off_value(), any16(), any16());
      send_element(r, r, diag_value(), any16(), z_value(), z_value());
      if ($urandom_range(0, 11) == 0) return;
    end
  endtask

  task automatic send_stray();
    int unsigned eff;
    int unsigned r;
    int unsigned c;
    eff = (order_now > MaxOrder) ? MaxOrder : order_now;
    if (eff == 0) begin
      send_element($urandom_range(0, 7), $urandom_range(0, 7), any16(), any16(), any16(),
                   any16());
      return;
    end
    case ($urandom_range(0, 3))
      0: begin
        r = $urandom_range(0, 6);
        c = $urandom_range(r + 1, 7);
        send_element(r, c, any16(), any16(), any16(), any16());
      end
      1: begin
        if (eff < MaxOrder) begin
          r = $urandom_range(eff, 7);
          c = $urandom_range(0, r);
          send_element(r, c, any16(), any16(), any16(), any16());
        end else begin
          send_element(eff - 1, eff - 1, diag_value(), any16(), z_value(), z_value());
        end
      end
      2: begin
        r = $urandom_range(0, eff - 1);
        c = (r == 0) ? 0 : $urandom_range(0, r - 1);
        if (r > 0 && written[c])
          send_element(r, c, off_value(), off_value(), any16(), any16());
        else
          send_element(r, r, diag_value(), any16(), z_value(), z_value());
      end
      default: begin
        r = $urandom_range(0, eff - 1);
        send_element(r, r, diag_value(), any16(), z_value(), z_value());
      end
    endcase
  endtask

  // output side: random stalls, one long hold to back the block up, always ready in the quiet phase
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (quiet) begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end else if (!held && counted >= HoldAfter) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned start;
    int unsigned eff;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // order 4 after reset: one system with extreme values
    send_element(0, 0, data_t'(4096), data_t'(-1), data_t'(32767), data_t'(-32768));
    send_element(1, 0, data_t'(32767), data_t'(-32768), '0, '0);
    send_element(1, 1, data_t'(32767), '0, '0, '0);
    send_element(2, 0, data_t'(-32768), data_t'(32767), data_t'(-1), data_t'(-1));
    send_element(2, 1, data_t'(1), data_t'(-1), '0, '0);
    send_element(2, 2, data_t'(1), data_t'(32767), data_t'(-32768), data_t'(32767));
    send_element(3, 0, '0, '0, '0, '0);
    send_element(3, 1, data_t'(-1), data_t'(-1), '0, '0);
    send_element(3, 2, data_t'(4096), '0, '0, '0);
    send_element(3, 3, data_t'(8192), data_t'(-32768), data_t'(1000), data_t'(-1000));
    // non-positive diagonals
    send_element(0, 0, '0, data_t'(5), data_t'(100), data_t'(100));
    send_element(1, 1, data_t'(-32768), '0, data_t'(7), data_t'(7));
    send_element(2, 2, data_t'(-1), '0, data_t'(7), data_t'(7));
    // column above row, rows outside the system
    send_element(1, 7, data_t'(4096), data_t'(4096), '0, '0);
    send_element(0, 1, data_t'(4096), data_t'(4096), '0, '0);
    send_element(5, 5, data_t'(4096), '0, data_t'(1), data_t'(1));
    send_element(7, 3, data_t'(4096), data_t'(4096), '0, '0);
    // halfway quotients round away from zero
    send_element(3, 3, data_t'(8192), '0, data_t'(1), data_t'(-1));

    for (int p = 0; p < NumPhases; p++) begin
      write_order(phase_orders[p]);
      if (p == NumPhases - 1) quiet = 1'b1;
      eff = (order_now > MaxOrder) ? MaxOrder : order_now;
      if (eff == 0) begin
        repeat (12) send_stray();
      end else begin
        start = counted;
        while (counted - start < PhaseItems) begin
          if ($urandom_range(0, 4) == 0) send_stray();
          else solve_system(eff);
        end
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk_i);
    $display("%0d solved elements checked (%0d with a non-positive diagonal) over %0d orders",
             solved, div_errors, NumPhases + 1);
    $display("included a %0d-cycle output hold, stray and broken sequences", HoldCycles);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
